// ----- hw/rtl/pa3d_pkg.sv -----
`timescale 1ns / 1ps
package pa3d_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_BITS  = 16;
  localparam int PROD_W      = 2 * COORD_BITS;      // one coordinate product
  localparam int DIFF_W      = PROD_W + 1;          // difference of two products
  localparam int TERM_W      = PROD_W + 2;          // edge term plus closing term
  localparam int SUM_W       = 48;                  // wrapping cross sums
  localparam int HALF_W      = SUM_W / 2;           // magnitude split for squaring
  localparam int SQ_W        = 2 * SUM_W;           // sum of the three squares
  localparam int ROOT_W      = SQ_W / 2;            // floor square root
  localparam int REM_W       = ROOT_W + 2;          // root remainder
  localparam int AREA_W      = 35;

  // Stream payload widths
  localparam int IN_DATA_W   = 3 * COORD_BITS;
  localparam int OUT_DATA_W  = ((AREA_W + 7) / 8) * 8;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;

  // One queued vertex: cross sum increments and polygon markers
  typedef struct packed {
    logic signed [TERM_W-1:0] term_x;
    logic signed [TERM_W-1:0] term_y;
    logic signed [TERM_W-1:0] term_z;
    logic                     first;
    logic                     last;
  } term_t;

endpackage

// ----- hw/rtl/polygon_area_3d.sv -----
`timescale 1ns / 1ps
// Area of a closed 3D polygon, streamed one vertex per transaction.
// Input channel: in_tdata carries signed Q8.8 x, y, z; in_tlast marks the
// final vertex, which closes the polygon back to its first vertex.
// Output channel: one transaction per polygon carrying the unsigned area in
// units of 2^-16 square units, half the length of the summed cross product,
// saturated to 35 bits. A single vertex polygon gives zero.
// Throughput: one vertex per cycle while the queue has room. Closing a
// polygon runs the back end through the final accumulate, the
// magnitude, nine 24x24 partial products for the three squares, a settle
// state and 48 steps of the restoring square root, then the output load.
// The front end keeps accepting vertices of the next polygon during that
// time until the queue of QUEUE_DEPTH entries fills.
// Reset clears the state machines, valid flags, queue pointers and cross sums; no polygon is open.
// When the receiver stalls, the result holds in the output register, the
// back end waits, and in_tready drops once the queue is full.
module polygon_area_3d #(
  parameter int QUEUE_DEPTH = pa3d_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pa3d_pkg::IN_DATA_W-1:0]      in_tdata,  // vertex_x, vertex_y, vertex_z
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pa3d_pkg::OUT_DATA_W-1:0]     out_tdata  // area, zero padded
);

  localparam int CW = pa3d_pkg::COORD_BITS;
  localparam int AW = pa3d_pkg::AREA_W;

  logic            q_push, q_pop, q_valid;
  pa3d_pkg::term_t q_wdata, q_rdata;
  logic [AW-1:0]   area;

  pa3d_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .vertex_x    ($signed(in_tdata[CW-1:0])),
    .vertex_y    ($signed(in_tdata[2*CW-1:CW])),
    .vertex_z    ($signed(in_tdata[3*CW-1:2*CW])),
    .last_vertex (in_tlast),
    .q_pop       (q_pop),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  pa3d_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  pa3d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .area       (area)
  );

  assign out_tdata = {{(pa3d_pkg::OUT_DATA_W - AW){1'b0}}, area};

endmodule

// ----- hw/rtl/pa3d_front.sv -----
`timescale 1ns / 1ps
module pa3d_front #(
  parameter int QUEUE_DEPTH = pa3d_pkg::QUEUE_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic signed [pa3d_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [pa3d_pkg::COORD_BITS-1:0] vertex_y,
  input  logic signed [pa3d_pkg::COORD_BITS-1:0] vertex_z,
  input  logic                                   last_vertex,
  input  logic                                   q_pop,
  output logic                                   q_push,
  output pa3d_pkg::term_t                        q_wdata
);

  localparam int CW  = pa3d_pkg::COORD_BITS;
  localparam int PW  = pa3d_pkg::PROD_W;
  localparam int DW  = pa3d_pkg::DIFF_W;
  localparam int TW  = pa3d_pkg::TERM_W;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [CW-1:0] prev_r  [3];
  logic signed [CW-1:0] first_r [3];
  logic                 in_poly_r;
  logic [OCC_W-1:0]     occ_r, occ_nxt;

  logic signed [CW-1:0] v [3];
  logic signed [CW-1:0] f [3];
  logic                 accept;

  // products of the edge cross and of the closing cross
  logic signed [PW-1:0] pc_r [6];
  logic signed [PW-1:0] pl_r [6];
  logic                 s1_valid_r;
  logic                 s1_first_r;
  logic                 s1_last_r;

  logic signed [DW-1:0] dc [3];
  logic signed [DW-1:0] dl [3];
  logic signed [TW-1:0] t  [3];

  assign v[0] = vertex_x;
  assign v[1] = vertex_y;
  assign v[2] = vertex_z;

  // space for every vertex in flight or queued
  assign in_tready = (occ_r < OCC_W'(QUEUE_DEPTH));
  assign accept    = in_tvalid && in_tready;

  // closing edge goes back to the stored first vertex, or to itself
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f[i] = in_poly_r ? first_r[i] : v[i];
    end
  end

  // track vertices between acceptance and hand-off to the back end
  always_comb begin
    occ_nxt = occ_r;
    if (accept && !q_pop) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!accept && q_pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      in_poly_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i]  <= '0;
        first_r[i] <= '0;
      end
    end else begin
      occ_r      <= occ_nxt;
      s1_valid_r <= accept;
      if (accept) begin
        in_poly_r <= !last_vertex;
        for (int i = 0; i < 3; i++) begin
          prev_r[i] <= v[i];
          if (!in_poly_r) begin
            first_r[i] <= v[i];
          end
        end
      end
    end
  end

  // stage one: twelve coordinate products
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_r <= !in_poly_r;
      s1_last_r  <= last_vertex;
      pc_r[0] <= PW'(prev_r[1]) * PW'(v[2]);
      pc_r[1] <= PW'(prev_r[2]) * PW'(v[1]);
      pc_r[2] <= PW'(prev_r[2]) * PW'(v[0]);
      pc_r[3] <= PW'(prev_r[0]) * PW'(v[2]);
      pc_r[4] <= PW'(prev_r[0]) * PW'(v[1]);
      pc_r[5] <= PW'(prev_r[1]) * PW'(v[0]);
      pl_r[0] <= PW'(v[1]) * PW'(f[2]);
      pl_r[1] <= PW'(v[2]) * PW'(f[1]);
      pl_r[2] <= PW'(v[2]) * PW'(f[0]);
      pl_r[3] <= PW'(v[0]) * PW'(f[2]);
      pl_r[4] <= PW'(v[0]) * PW'(f[1]);
      pl_r[5] <= PW'(v[1]) * PW'(f[0]);
    end
  end

  // stage two: combine edge and closing terms, write into the queue
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dc[i] = DW'(pc_r[2*i]) - DW'(pc_r[2*i+1]);
      dl[i] = DW'(pl_r[2*i]) - DW'(pl_r[2*i+1]);
      t[i]  = (s1_first_r ? '0 : TW'(dc[i])) + (s1_last_r ? TW'(dl[i]) : '0);
    end
  end

  assign q_push          = s1_valid_r;
  assign q_wdata.term_x  = t[0];
  assign q_wdata.term_y  = t[1];
  assign q_wdata.term_z  = t[2];
  assign q_wdata.first   = s1_first_r;
  assign q_wdata.last    = s1_last_r;

endmodule

// ----- hw/rtl/pa3d_queue.sv -----
`timescale 1ns / 1ps
module pa3d_queue #(
  parameter int QUEUE_DEPTH = pa3d_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pa3d_pkg::term_t wdata,
  input  logic            pop,
  output logic            rvalid,
  output pa3d_pkg::term_t rdata
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pa3d_pkg::term_t  mem_r [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  // store entries; the front end never pushes into a full queue
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + IDX_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (!push && pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/pa3d_back.sv -----
`timescale 1ns / 1ps
module pa3d_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  pa3d_pkg::term_t               q_rdata,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pa3d_pkg::AREA_W-1:0]   area
);

  localparam int SW = pa3d_pkg::SUM_W;
  localparam int HW = pa3d_pkg::HALF_W;
  localparam int QW = pa3d_pkg::SQ_W;
  localparam int RW = pa3d_pkg::ROOT_W;
  localparam int MW = pa3d_pkg::REM_W;
  localparam int AW = pa3d_pkg::AREA_W;
  localparam int TW = pa3d_pkg::TERM_W;
  localparam int CNT_W = $clog2(RW);

  // which partial product of a square is issued
  localparam logic [1:0] PART_HH = 2'd0;
  localparam logic [1:0] PART_HL = 2'd1;
  localparam logic [1:0] PART_LL = 2'd2;
  localparam logic [1:0] AXIS_Z  = 2'd2;

  typedef enum logic [5:0] {
    ST_ACC  = 6'b000001,
    ST_MAG  = 6'b000010,
    ST_SQ   = 6'b000100,
    ST_FIN  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SW-1:0]     sum_r [3];
  logic [SW-1:0]     mag_r [3];
  logic [1:0]        axis_r, part_r;
  logic [2*HW-1:0]   prod_r;
  logic [1:0]        prod_part_r;
  logic              prod_valid_r;
  logic [QW-1:0]     acc_r, acc_nxt, prod_sh;
  logic [RW-1:0]     root_r;
  logic [MW-1:0]     rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [AW-1:0]     area_r;

  logic signed [TW-1:0] term [3];
  logic [SW-1:0]     mag_sel;
  logic [HW-1:0]     op_a, op_b;
  logic [MW+1:0]     rem_sh, trial;
  logic              ge;
  logic [RW-2:0]     half;
  logic [AW-1:0]     area_sat;
  logic              out_load;

  assign term[0] = q_rdata.term_x;
  assign term[1] = q_rdata.term_y;
  assign term[2] = q_rdata.term_z;

  assign q_pop      = (state_r == ST_ACC) && q_valid;
  assign out_tvalid = out_valid_r;
  assign area       = area_r;

  // operands of the shared squaring multiplier
  assign mag_sel = mag_r[axis_r];
  always_comb begin
    case (part_r)
      PART_HH: begin
        op_a = mag_sel[SW-1:HW];
        op_b = mag_sel[SW-1:HW];
      end
      PART_HL: begin
        op_a = mag_sel[SW-1:HW];
        op_b = mag_sel[HW-1:0];
      end
      default: begin
        op_a = mag_sel[HW-1:0];
        op_b = mag_sel[HW-1:0];
      end
    endcase
  end

  // place the registered product at its weight; cross products count twice
  always_comb begin
    case (prod_part_r)
      PART_HH: prod_sh = {prod_r, {(2*HW){1'b0}}};
      PART_HL: prod_sh = {{(QW-2*HW-HW-1){1'b0}}, prod_r, {(HW+1){1'b0}}};
      default: prod_sh = {{(QW-2*HW){1'b0}}, prod_r};
    endcase
  end

  // one restoring square root step, two radicand bits at a time
  assign rem_sh = {rem_r, acc_r[QW-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  // halve the root and saturate
  assign half     = root_r[RW-1:1];
  assign area_sat = (|half[RW-2:AW]) ? {AW{1'b1}} : half[AW-1:0];
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // radicand accumulator and shift register
  always_comb begin
    acc_nxt = acc_r;
    if (state_r == ST_MAG) begin
      acc_nxt = '0;
    end else if (prod_valid_r) begin
      acc_nxt = acc_r + prod_sh;
    end else if (state_r == ST_ROOT) begin
      acc_nxt = {acc_r[QW-3:0], 2'b00};
    end
  end

  // sequence the polygon close
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_ACC:  if (q_pop && q_rdata.last) state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_SQ;
      ST_SQ:   if (axis_r == AXIS_Z && part_r == PART_LL) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_ROOT;
      ST_ROOT: if (cnt_r == CNT_W'(RW - 1)) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_ACC;
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_ACC;
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      prod_valid_r <= (state_r == ST_SQ);
      // accumulate cross sums, restarting on the first vertex
      if (q_pop) begin
        for (int i = 0; i < 3; i++) begin
          sum_r[i] <= (q_rdata.first ? '0 : sum_r[i])
                      + {{(SW-TW){term[i][TW-1]}}, term[i]};
        end
      end
      // hold the result until the receiver takes it
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    case (state_r)
      ST_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= sum_r[i][SW-1] ? (~sum_r[i] + SW'(1)) : sum_r[i];
        end
        axis_r <= '0;
        part_r <= PART_HH;
      end
      ST_SQ: begin
        prod_r      <= (2*HW)'(op_a) * (2*HW)'(op_b);
        prod_part_r <= part_r;
        if (part_r == PART_LL) begin
          part_r <= PART_HH;
          axis_r <= axis_r + 2'd1;
        end else begin
          part_r <= part_r + 2'd1;
        end
      end
      ST_FIN: begin
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      ST_ROOT: begin
        rem_r  <= ge ? MW'(rem_sh - trial) : MW'(rem_sh);
        root_r <= {root_r[RW-2:0], ge};
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      area_r <= area_sat;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

  localparam int COORD_BITS = pa3d_pkg::COORD_BITS;
  localparam int AREA_W     = pa3d_pkg::AREA_W;
  localparam int SUM_W      = pa3d_pkg::SUM_W;
  localparam int IN_DATA_W  = pa3d_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = pa3d_pkg::OUT_DATA_W;

  localparam int IDLE_LIMIT      = 4000;
  localparam int END_WAIT        = 100;
  localparam int RANDOM_VERTICES = 1400;
  localparam int LONG_LOOPS      = 48;
  localparam int PRINT_LIMIT     = 100;
  localparam int ROOT_CALC_W     = 100;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [AREA_W-1:0] area_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam area_t  AREA_MAX  = '1;

  typedef enum {COORD_FULL, COORD_EDGE, COORD_SMALL, COORD_MIXED} coord_mode_t;
  typedef enum {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_mode_t;

  // Tracks the open polygon and the areas still owed by the block
  class area_tracker;
    longint first_pt[3];
    longint prev_pt[3];
    logic [SUM_W-1:0] cross_acc[3];
    bit polygon_open;
    area_t expected_area[$];
    int errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        first_pt[i]  = 0;
        prev_pt[i]   = 0;
        cross_acc[i] = '0;
      end
      polygon_open = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_area.size();
    endfunction

    // Add one edge cross product into the wrapping sums
    function void add_edge(input longint a[3], input longint b[3]);
      longint c[3];
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      for (int i = 0; i < 3; i++)
        cross_acc[i] = cross_acc[i] + SUM_W'(c[i]);
    endfunction

    function logic [SUM_W-1:0] magnitude(input logic [SUM_W-1:0] s);
      return s[SUM_W-1] ? -s : s;
    endfunction

    // Half the floor root of the squared sum vector length, saturated
    function area_t area_of_sums();
      logic [ROOT_CALC_W-1:0] acc, m, t, root;
      acc  = '0;
      root = '0;
      for (int i = 0; i < 3; i++) begin
        m   = ROOT_CALC_W'(magnitude(cross_acc[i]));
        acc = acc + m * m;
      end
      for (int k = SUM_W; k >= 0; k--) begin
        t = root | (ROOT_CALC_W'(1) << k);
        if (t * t <= acc) root = t;
      end
      root = root >> 1;
      if (root > ROOT_CALC_W'(AREA_MAX)) return AREA_MAX;
      return root[AREA_W-1:0];
    endfunction

    function void take_vertex(input coord_t x, input coord_t y, input coord_t z, input bit last);
      longint v[3];
      v[0] = x;
      v[1] = y;
      v[2] = z;
      if (!polygon_open) begin
        first_pt = v;
        for (int i = 0; i < 3; i++) cross_acc[i] = '0;
        polygon_open = 1'b1;
      end else begin
        add_edge(prev_pt, v);
      end
      prev_pt = v;
      if (last) begin
        add_edge(prev_pt, first_pt);
        expected_area = {expected_area, area_of_sums()};
        polygon_open = 1'b0;
      end
    endfunction

    task flag_mismatch(input string msg);
      if (errors < PRINT_LIMIT) $display("%0t: %s", $time, msg);
      errors++;
    endtask

    task check_area(input area_t got);
      area_t want;
      if (expected_area.size() == 0) begin
        flag_mismatch($sformatf("area %0d with no polygon closed", got));
        return;
      end
      want = expected_area.pop_front();
      if (got !== want) flag_mismatch($sformatf("area %0d, expected %0d", got, want));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // vertex_x, vertex_y, vertex_z
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // area, zero padded

  area_tracker tracker = new();

  int          idle_cycles  = 0;
  int          burst_left   = 0;
  ready_mode_t ready_mode   = READY_ALWAYS;
  int          mode_left    = 0;
  int          ready_phase  = 0;
  int          ready_period = 8;
  int          ready_low    = 3;

  polygon_area_3d dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Check results first, then note accepted vertices; watch for a hang
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_area(out_tdata[AREA_W-1:0]);
    if (rst_n && in_tvalid && in_tready)
      tracker.take_vertex(coord_t'(in_tdata[COORD_BITS-1:0]),
                          coord_t'(in_tdata[2*COORD_BITS-1:COORD_BITS]),
                          coord_t'(in_tdata[3*COORD_BITS-1:2*COORD_BITS]), in_tlast);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL polygon_area_3d");
      $finish;
    end
  end

  // Receiver backpressure: switch between randomly chosen stall styles
  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left    = $urandom_range(64, 600);
      ready_mode   = ready_mode_t'($urandom_range(0, 3));
      ready_period = $urandom_range(2, 40);
      ready_low    = $urandom_range(1, ready_period - 1);
    end
    mode_left--;
    ready_phase = (ready_phase + 1) % ready_period;
    case (ready_mode)
      READY_ALWAYS:  out_tready <= 1'b1;
      READY_COIN:    out_tready <= ($urandom_range(0, 1) == 1);
      READY_PATTERN: out_tready <= (ready_phase >= ready_low);
      default:       out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Present one vertex, sometimes after an idle gap, and hold it until the transaction completes
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off the sender until every closed polygon has reported
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  function automatic coord_t pick_coord(input coord_mode_t mode);
    coord_mode_t m;
    m = (mode == COORD_MIXED) ? coord_mode_t'($urandom_range(0, 2)) : mode;
    case (m)
      COORD_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return '0;
          3:       return '1;
          default: return coord_t'(1);
        endcase
      end
      COORD_SMALL: return coord_t'($urandom_range(0, 511)) - 16'sd256;
      default:     return coord_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Walk the extreme square loops times so the sums grow large
  task automatic winding_polygon(input int loops, input bit reverse, input bit jitter);
    coord_t cx[4];
    coord_t cy[4];
    coord_t z;
    int k;
    cx = '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX};
    cy = '{COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN};
    for (int i = 0; i < 4 * loops; i++) begin
      k = reverse ? 3 - (i % 4) : i % 4;
      z = jitter ? coord_t'($urandom_range(0, 63)) : coord_t'(0);
      send_vertex(cx[k], cy[k], z, i == 4 * loops - 1);
    end
  endtask

  task automatic random_polygon(inout int sent);
    int n;
    int pick;
    int loops;
    coord_mode_t mode;
    pick = $urandom_range(0, 99);
    if (pick < 6) n = 1;
    else if (pick < 12) n = 2;
    else if (pick < 75) n = $urandom_range(3, 8);
    else if (pick < 95) n = $urandom_range(9, 40);
    else n = 0;
    if (n == 0) begin
      loops = $urandom_range(2, 40);
      winding_polygon(loops, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      sent += 4 * loops;
    end else begin
      mode = coord_mode_t'($urandom_range(0, 3));
      for (int i = 0; i < n; i++)
        send_vertex(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == n - 1);
      sent += n;
    end
  endtask

  initial begin
    int sent;
    bit long_done;
    sent = 0;
    long_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single vertex polygons close on themselves
    send_vertex(COORD_MAX, COORD_MIN, coord_t'(0), 1'b1);
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
    // Two vertices cancel
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    // Unit-ish right triangle
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0);
    send_vertex(coord_t'(256), coord_t'(0), coord_t'(0), 1'b0);
    send_vertex(coord_t'(0), coord_t'(256), coord_t'(0), 1'b1);
    // Extreme coordinates
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, coord_t'(0), coord_t'(0), 1'b0);
    send_vertex(coord_t'(0), COORD_MAX, COORD_MIN, 1'b1);
    winding_polygon(1, 1'b0, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
    // Collinear points give no area
    send_vertex(coord_t'(1), coord_t'(2), coord_t'(3), 1'b0);
    send_vertex(coord_t'(2), coord_t'(4), coord_t'(6), 1'b0);
    send_vertex(coord_t'(-1), coord_t'(-2), coord_t'(-3), 1'b1);
    wait_for_results();

    // Random polygons; one long winding drives the area deep into saturation
    while (sent < RANDOM_VERTICES) begin
      random_polygon(sent);
      if (!long_done && sent >= RANDOM_VERTICES / 2) begin
        winding_polygon(LONG_LOOPS, 1'($urandom_range(0, 1)), 1'b0);
        sent += 4 * LONG_LOOPS;
        long_done = 1'b1;
      end
      if ($urandom_range(0, 49) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (END_WAIT) @(posedge clk);
    if (tracker.errors == 0)
      $display("PASS polygon_area_3d");
    else
      $display("FAIL polygon_area_3d");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pa3d_pkg.sv
hw/rtl/pa3d_front.sv
hw/rtl/pa3d_queue.sv
hw/rtl/pa3d_back.sv
hw/rtl/polygon_area_3d.sv
tb/tb.sv
